### hdl/six_register_instruction_executor_defines.svh
// Assertion macros shared by the executor's checker
`ifndef SIX_REGISTER_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define SIX_REGISTER_INSTRUCTION_EXECUTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SRIE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SRIE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/srie_pkg.sv
// Types, constants and opcode helpers for the six-register executor
package srie_pkg;

	localparam int NUM_REGS  = 6;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int DATA_W    = 32;
	localparam int DIV_CNT_W = $clog2(DATA_W);
	localparam int OPC_W     = 5;
	localparam int DEST_W    = 3;
	localparam int IPIDX_W   = 3;
	localparam int PLEN_W    = 16;

	typedef enum logic [OPC_W-1:0] {
		OP_ADDR = 5'd0,
		OP_ADDI = 5'd1,
		OP_MULR = 5'd2,
		OP_MULI = 5'd3,
		OP_BANR = 5'd4,
		OP_BANI = 5'd5,
		OP_BORR = 5'd6,
		OP_BORI = 5'd7,
		OP_SETR = 5'd8,
		OP_SETI = 5'd9,
		OP_GTIR = 5'd10,
		OP_GTRI = 5'd11,
		OP_GTRR = 5'd12,
		OP_EQIR = 5'd13,
		OP_EQRI = 5'd14,
		OP_EQRR = 5'd15,
		OP_DIVR = 5'd16,
		OP_DIVI = 5'd17
	} srie_op_t;

	typedef enum logic {
		CFG_IP_INDEX = 1'b0,
		CFG_PROG_LEN = 1'b1
	} srie_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_WB
	} srie_state_t;

	typedef struct packed {
		logic [OPC_W-1:0]  opcode;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
		logic [DEST_W-1:0] dest_index;
	} srie_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] next_ip;
		logic [DATA_W-1:0] written_value;
		logic              halted;
		logic              bad_index;
		logic              divide_by_zero;
		logic              watch_hit;
		logic [DATA_W-1:0] watch_value;
	} srie_out_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic div_wr;
		logic wb;
	} srie_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_op;
		logic div_done;
		logic out_free;
	} srie_stat_t;

	function automatic logic op_reads_a(input logic [OPC_W-1:0] op);
		logic r;
		case (srie_op_t'(op))
			OP_ADDR, OP_ADDI, OP_MULR, OP_MULI, OP_BANR, OP_BANI, OP_BORR, OP_BORI,
			OP_SETR, OP_GTRI, OP_GTRR, OP_EQRI, OP_EQRR, OP_DIVR, OP_DIVI: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic op_reads_b(input logic [OPC_W-1:0] op);
		logic r;
		case (srie_op_t'(op))
			OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR,
			OP_DIVR: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic op_defined(input logic [OPC_W-1:0] op);
		return op <= OPC_W'(OP_DIVI);
	endfunction

endpackage

### hdl/srie_div.sv
// Radix-2 restoring divider, one quotient bit per cycle
module srie_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [srie_pkg::DATA_W-1:0] dividend,
	input  logic [srie_pkg::DATA_W-1:0] divisor,
	output logic                        done,
	output logic [srie_pkg::DATA_W-1:0] quotient
);
	import srie_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dvs_q;
	logic [DATA_W:0]      shifted;
	logic [DATA_W:0]      diff;
	logic                 qbit;
	logic [DATA_W-1:0]    nrem;

	always_comb begin
		shifted = {rem_q, quo_q[DATA_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		qbit    = ~diff[DATA_W];
		nrem    = qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= nrem;
			quo_q <= {quo_q[DATA_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hdl/srie_datapath.sv
// Register file, ALU, divider, config registers and result register
module srie_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  srie_pkg::srie_cmd_t          cmd,
	output srie_pkg::srie_stat_t         stat,
	input  srie_pkg::srie_in_t           instr,
	output logic                         result_valid,
	input  logic                         result_ready,
	output srie_pkg::srie_out_t          result,
	input  logic                         cfg_valid,
	input  srie_pkg::srie_cfg_t          cfg_index,
	input  logic [srie_pkg::PLEN_W-1:0]  cfg_data
);
	import srie_pkg::*;

	localparam logic [DATA_W-1:0] NREGS = DATA_W'(NUM_REGS);

	// config
	logic [IPIDX_W-1:0] ip_idx_q;
	logic [PLEN_W-1:0]  plen_q;

	// instruction held for execution
	logic [OPC_W-1:0]  op_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DEST_W-1:0] c_q;

	// register file
	logic [DATA_W-1:0]    mem_q [NUM_REGS];
	logic [NUM_REGS-1:0]  vld_q;
	logic                 we;
	logic [REG_IDX_W-1:0] wa;
	logic [DATA_W-1:0]    wd;
	logic                 rea;
	logic [REG_IDX_W-1:0] ra;
	logic [REG_IDX_W-1:0] rb;
	logic [DATA_W-1:0]    rda_q;
	logic [DATA_W-1:0]    rdb_q;

	// execute
	logic                 a_ok, b_ok, c_ok, ip_ok;
	logic [REG_IDX_W-1:0] c_addr, ip_addr;
	logic [DATA_W-1:0]    va, vb, mul_rhs, prod, divisor, alu_wv;
	logic                 is_div, div_zero, div_op;
	logic                 bad, watch;
	logic [DATA_W-1:0]    wval;
	logic                 div_done;
	logic [DATA_W-1:0]    quotient;

	// results of execute
	logic [DATA_W-1:0] wv_q;
	logic              bad_q, dz_q, watch_q;
	logic [DATA_W-1:0] wval_q;
	logic [DATA_W-1:0] nip;

	srie_out_t res_q;
	logic      res_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_idx_q <= '0;
			plen_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IP_INDEX: ip_idx_q <= cfg_data[IPIDX_W-1:0];
				CFG_PROG_LEN: plen_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= instr.opcode;
			a_q  <= instr.operand_a;
			b_q  <= instr.operand_b;
			c_q  <= instr.dest_index;
		end
	end

	assign a_ok    = a_q < NREGS;
	assign b_ok    = b_q < NREGS;
	assign c_ok    = DATA_W'(c_q) < NREGS;
	assign ip_ok   = DATA_W'(ip_idx_q) < NREGS;
	assign c_addr  = c_ok ? REG_IDX_W'(c_q) : '0;
	assign ip_addr = ip_ok ? REG_IDX_W'(ip_idx_q) : '0;

	// out-of-range operands read as zero
	assign va = a_ok ? rda_q : '0;
	assign vb = b_ok ? rdb_q : '0;

	assign mul_rhs = (srie_op_t'(op_q) == OP_MULR) ? vb : b_q;
	assign prod    = va * mul_rhs;
	assign is_div  = (srie_op_t'(op_q) == OP_DIVR) || (srie_op_t'(op_q) == OP_DIVI);
	assign divisor = (srie_op_t'(op_q) == OP_DIVR) ? vb : b_q;
	assign div_zero = divisor == '0;
	assign div_op  = is_div && !div_zero;

	always_comb begin
		case (srie_op_t'(op_q))
			OP_ADDR: alu_wv = va + vb;
			OP_ADDI: alu_wv = va + b_q;
			OP_MULR, OP_MULI: alu_wv = prod;
			OP_BANR: alu_wv = va & vb;
			OP_BANI: alu_wv = va & b_q;
			OP_BORR: alu_wv = va | vb;
			OP_BORI: alu_wv = va | b_q;
			OP_SETR: alu_wv = va;
			OP_SETI: alu_wv = a_q;
			OP_GTIR: alu_wv = {{(DATA_W-1){1'b0}}, a_q > vb};
			OP_GTRI: alu_wv = {{(DATA_W-1){1'b0}}, va > b_q};
			OP_GTRR: alu_wv = {{(DATA_W-1){1'b0}}, va > vb};
			OP_EQIR: alu_wv = {{(DATA_W-1){1'b0}}, a_q == vb};
			OP_EQRI: alu_wv = {{(DATA_W-1){1'b0}}, va == b_q};
			OP_EQRR: alu_wv = {{(DATA_W-1){1'b0}}, va == vb};
			OP_DIVR, OP_DIVI: alu_wv = div_zero ? '1 : '0;
			default: alu_wv = '0;
		endcase
	end

	assign bad = (op_reads_a(op_q) && !a_ok) || (op_reads_b(op_q) && !b_ok) ||
		(op_defined(op_q) && !c_ok) || !ip_ok;
	assign watch = (srie_op_t'(op_q) == OP_EQRR) && (a_q == '0 || b_q == '0);
	// the register compared against r0
	assign wval = (a_q == '0) ? vb : va;

	srie_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.exec && div_op),
		.dividend (va),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// single write port: dest in execute (or at divide end), ip in writeback
	always_comb begin
		we = 1'b0;
		wa = c_addr;
		wd = alu_wv;
		if (cmd.exec) begin
			we = !div_op && op_defined(op_q) && c_ok;
		end
		if (cmd.div_wr) begin
			we = c_ok;
			wd = quotient;
		end
		if (cmd.wb) begin
			we = ip_ok;
			wa = ip_addr;
			wd = nip;
		end
	end

	// port A reads operand a on accept, the ip register once dest is written
	assign rea = cmd.accept || (cmd.exec && !div_op) || cmd.div_wr;
	assign ra  = cmd.accept ?
		((instr.operand_a < NREGS) ? instr.operand_a[REG_IDX_W-1:0] : '0) : ip_addr;
	assign rb  = (instr.operand_b < NREGS) ? instr.operand_b[REG_IDX_W-1:0] : '0;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[wa] <= 1'b1;
		end
	end

	// write-first read ports; unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (rea) begin
			if (we && wa == ra) begin
				rda_q <= wd;
			end else begin
				rda_q <= vld_q[ra] ? mem_q[ra] : '0;
			end
		end
		if (cmd.accept) begin
			if (we && wa == rb) begin
				rdb_q <= wd;
			end else begin
				rdb_q <= vld_q[rb] ? mem_q[rb] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			wv_q    <= alu_wv;
			bad_q   <= bad;
			dz_q    <= is_div && div_zero;
			watch_q <= watch;
			wval_q  <= watch ? wval : '0;
		end else if (cmd.div_wr) begin
			wv_q <= quotient;
		end
	end

	assign nip = ip_ok ? rda_q + 1'b1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (cmd.wb) begin
			res_vld_q <= 1'b1;
		end else if (result_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			res_q.next_ip        <= nip;
			res_q.written_value  <= wv_q;
			res_q.halted         <= nip >= DATA_W'(plen_q);
			res_q.bad_index      <= bad_q;
			res_q.divide_by_zero <= dz_q;
			res_q.watch_hit      <= watch_q;
			res_q.watch_value    <= wval_q;
		end
	end

	assign result_valid  = res_vld_q;
	assign result        = res_q;
	assign stat.div_op   = div_op;
	assign stat.div_done = div_done;
	assign stat.out_free = !res_vld_q || result_ready;

endmodule

### hdl/srie_ctrl.sv
// Sequencing state machine: accept, execute, divide wait, writeback
module srie_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 instr_valid,
	output logic                 instr_ready,
	input  srie_pkg::srie_stat_t stat,
	output srie_pkg::srie_cmd_t  cmd
);
	import srie_pkg::*;

	srie_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (instr_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = stat.div_op ? ST_DIV : ST_WB;
			end
			ST_DIV: begin
				if (stat.div_done) state_nxt = ST_WB;
			end
			ST_WB: begin
				if (stat.out_free) state_nxt = instr_valid ? ST_EXEC : ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// next beat is taken while the finished one goes out
	always_comb begin
		instr_ready = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: instr_ready = 1'b1;
			ST_EXEC: cmd.exec = 1'b1;
			ST_DIV:  cmd.div_wr = stat.div_done;
			ST_WB: begin
				instr_ready = stat.out_free;
				cmd.wb      = stat.out_free;
			end
			default: ;
		endcase
		cmd.accept = instr_valid && instr_ready;
	end

endmodule

### hdl/six_register_instruction_executor.sv
// Top level of the six-register instruction executor
//
// instr channel (valid/ready): one instruction per beat: opcode, operands a and b,
// destination index. result channel (valid/ready): one result beat per instruction,
// in order: next_ip, written_value and the halt/fault/watch flags.
// cfg channel (valid/ready, always ready): index 0 binds the ip register, index 1
// sets the program length. Write it only while no instruction is in flight.
// An instruction is registered on accept, executed, and its result registered in
// writeback. New instructions are taken only in idle or writeback, alternating with
// execute, bounded by the single write port of the register file. A divide with
// nonzero divisor waits in the radix-2 divider, one quotient bit per cycle.
// Reset marks all registers unwritten so they read as zero, and clears the config to zero; nothing is in flight.
// When the receiver stalls, the result holds in the output register, the block
// stops in writeback and takes no new instruction until the result drains.
module six_register_instruction_executor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        instr_valid,
	output logic                        instr_ready,
	input  srie_pkg::srie_in_t          instr,
	output logic                        result_valid,
	input  logic                        result_ready,
	output srie_pkg::srie_out_t         result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  srie_pkg::srie_cfg_t         cfg_index,
	input  logic [srie_pkg::PLEN_W-1:0] cfg_data
);
	import srie_pkg::*;

	srie_cmd_t  cmd;
	srie_stat_t stat;

	assign cfg_ready = 1'b1;

	srie_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_ready (instr_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	srie_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.instr        (instr),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

endmodule

### hdl/srie_checker.sv
// Port-level checks on the executor, bound to the top level
`include "six_register_instruction_executor_defines.svh"

module srie_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        instr_valid,
	input logic                        instr_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input srie_pkg::srie_out_t         result
);
	import srie_pkg::*;

	`SRIE_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")
	`SRIE_ASSERT_NEXT(a_busy_after_accept, instr_valid && instr_ready, !instr_ready, "beat taken during execute")
	`SRIE_ASSERT_IMPL(a_dz_ones, result_valid && result.divide_by_zero, result.written_value == '1, "zero divide must give all ones")
	`SRIE_ASSERT_IMPL(a_watch_bool, result_valid && result.watch_hit, result.written_value[DATA_W-1:1] == '0, "watched eqrr result not boolean")

endmodule

bind six_register_instruction_executor srie_checker u_srie_checker (.*);

### verif/six_register_instruction_executor_tb.sv
// Self-checking testbench for the six-register instruction executor
module six_register_instruction_executor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srie_pkg::*;

	localparam logic [OPC_W-1:0]   OP_UNDEF_LO = 5'd18;
	localparam logic [OPC_W-1:0]   OP_UNDEF_HI = 5'd31;
	localparam logic [IPIDX_W-1:0] IP_UNBOUND  = 3'd7;
	localparam int PHASE_ITEMS = 65;
	localparam int NUM_PHASES  = 6;

	// Shadow of the register machine: tracks registers and config, queues expected beats
	class reg_machine_shadow;
		logic [DATA_W-1:0]  regs [NUM_REGS];
		logic [IPIDX_W-1:0] ip_sel;
		logic [PLEN_W-1:0]  prog_len;
		bit                 idx_fault;
		int                 mismatches;
		srie_out_t          due_results [$];

		function new();
			foreach (regs[k]) regs[k] = '0;
			ip_sel = '0;
			prog_len = '0;
			mismatches = 0;
		endfunction

		function void set_cfg(srie_cfg_t idx, logic [PLEN_W-1:0] data);
			if (idx == CFG_IP_INDEX)
				ip_sel = data[IPIDX_W-1:0];
			else
				prog_len = data;
		endfunction

		function logic [DATA_W-1:0] read_reg(logic [DATA_W-1:0] idx, bit mark);
			if (idx >= NUM_REGS) begin
				if (mark) idx_fault = 1'b1;
				return '0;
			end
			return regs[idx];
		endfunction

		function void apply_instr(srie_in_t i);
			srie_out_t         e;
			logic [DATA_W-1:0] x, y, wv;
			bit                defined;
			e = '0;
			wv = '0;
			defined = 1'b1;
			idx_fault = 1'b0;
			// watch reads never raise the index flag on their own
			if (i.opcode == OP_EQRR && (i.operand_a == 0 || i.operand_b == 0)) begin
				e.watch_hit = 1'b1;
				e.watch_value = (i.operand_a == 0) ? read_reg(i.operand_b, 1'b0)
					: read_reg(i.operand_a, 1'b0);
			end
			case (i.opcode)
				OP_ADDR: wv = read_reg(i.operand_a, 1) + read_reg(i.operand_b, 1);
				OP_ADDI: wv = read_reg(i.operand_a, 1) + i.operand_b;
				OP_MULR: wv = read_reg(i.operand_a, 1) * read_reg(i.operand_b, 1);
				OP_MULI: wv = read_reg(i.operand_a, 1) * i.operand_b;
				OP_BANR: wv = read_reg(i.operand_a, 1) & read_reg(i.operand_b, 1);
				OP_BANI: wv = read_reg(i.operand_a, 1) & i.operand_b;
				OP_BORR: wv = read_reg(i.operand_a, 1) | read_reg(i.operand_b, 1);
				OP_BORI: wv = read_reg(i.operand_a, 1) | i.operand_b;
				OP_SETR: wv = read_reg(i.operand_a, 1);
				OP_SETI: wv = i.operand_a;
				OP_GTIR: wv = (i.operand_a > read_reg(i.operand_b, 1)) ? 1 : 0;
				OP_GTRI: wv = (read_reg(i.operand_a, 1) > i.operand_b) ? 1 : 0;
				OP_GTRR: begin
					x = read_reg(i.operand_a, 1);
					y = read_reg(i.operand_b, 1);
					wv = (x > y) ? 1 : 0;
				end
				OP_EQIR: wv = (i.operand_a == read_reg(i.operand_b, 1)) ? 1 : 0;
				OP_EQRI: wv = (read_reg(i.operand_a, 1) == i.operand_b) ? 1 : 0;
				OP_EQRR: begin
					x = read_reg(i.operand_a, 1);
					y = read_reg(i.operand_b, 1);
					wv = (x == y) ? 1 : 0;
				end
				OP_DIVR, OP_DIVI: begin
					x = read_reg(i.operand_a, 1);
					y = (i.opcode == OP_DIVR) ? read_reg(i.operand_b, 1) : i.operand_b;
					if (y == 0) begin
						e.divide_by_zero = 1'b1;
						wv = '1;
					end else begin
						wv = x / y;
					end
				end
				default: defined = 1'b0;
			endcase
			if (defined) begin
				if (i.dest_index < NUM_REGS)
					regs[i.dest_index] = wv;
				else
					idx_fault = 1'b1;
			end
			if (ip_sel < NUM_REGS) begin
				regs[ip_sel] = regs[ip_sel] + 1;
				e.next_ip = regs[ip_sel];
			end else begin
				idx_fault = 1'b1;
				e.next_ip = '0;
			end
			e.written_value = wv;
			e.halted = (e.next_ip >= {16'b0, prog_len});
			e.bad_index = idx_fault;
			due_results.insert(due_results.size(), e);
		endfunction

		function void check_field(string name, logic [DATA_W-1:0] e, logic [DATA_W-1:0] g);
			if (g !== e) begin
				$error("%s: expected %h, got %h", name, e, g);
				mismatches++;
			end
		endfunction

		function void match_result(srie_out_t got);
			srie_out_t e;
			if (due_results.size() == 0) begin
				$error("result beat with no instruction outstanding");
				mismatches++;
				return;
			end
			e = due_results.pop_front();
			check_field("next_ip", e.next_ip, got.next_ip);
			check_field("written_value", e.written_value, got.written_value);
			check_field("halted", e.halted, got.halted);
			check_field("bad_index", e.bad_index, got.bad_index);
			check_field("divide_by_zero", e.divide_by_zero, got.divide_by_zero);
			check_field("watch_hit", e.watch_hit, got.watch_hit);
			check_field("watch_value", e.watch_value, got.watch_value);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              instr_valid;
	logic              instr_ready;
	srie_in_t          instr;
	logic              result_valid;
	logic              result_ready;
	srie_out_t         result;
	logic              cfg_valid;
	logic              cfg_ready;
	srie_cfg_t         cfg_index;
	logic [PLEN_W-1:0] cfg_data;

	reg_machine_shadow shadow = new();
	bit                quiet = 1'b0;

	six_register_instruction_executor dut (
		.clk(clk),
		.arst_n(arst_n),
		.instr_valid(instr_valid),
		.instr_ready(instr_ready),
		.instr(instr),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("six_register_instruction_executor_tb NOT OK");
		$finish;
	end

	// result side: random stall bursts until the quiet tail
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid && result_ready)
			shadow.match_result(result);

	task automatic send_instr(srie_in_t item);
		@(negedge clk);
		instr_valid <= 1'b1;
		instr <= item;
		do @(posedge clk); while (!instr_ready);
		shadow.apply_instr(item);
	endtask

	task automatic issue(logic [OPC_W-1:0] op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
		logic [DEST_W-1:0] c);
		srie_in_t item;
		item.opcode = op;
		item.operand_a = a;
		item.operand_b = b;
		item.dest_index = c;
		send_instr(item);
	endtask

	task automatic idle_sender(int n);
		@(negedge clk);
		instr_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic write_cfg(srie_cfg_t idx, logic [PLEN_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		shadow.set_cfg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold off the sender until every outstanding beat has come back
	task automatic drain();
		idle_sender(1);
		while (shadow.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, NUM_REGS - 1);
			6: return $urandom_range(NUM_REGS, 7);
			7: return $urandom;
			8: return $urandom_range(0, 20);
			default: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic srie_in_t rand_instr();
		srie_in_t item;
		if ($urandom_range(0, 99) < 6)
			item.opcode = OPC_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
		else
			item.opcode = OPC_W'($urandom_range(OP_ADDR, OP_DIVI));
		item.operand_a = pick_operand();
		item.operand_b = pick_operand();
		if ($urandom_range(0, 9) == 0)
			item.dest_index = DEST_W'($urandom_range(NUM_REGS, 7));
		else
			item.dest_index = DEST_W'($urandom_range(0, NUM_REGS - 1));
		return item;
	endfunction

	initial begin
		logic [IPIDX_W-1:0] ip_plan [NUM_PHASES];
		logic [PLEN_W-1:0]  len_plan [NUM_PHASES];
		arst_n = 1'b0;
		instr_valid = 1'b0;
		instr = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IP_INDEX;
		cfg_data = '0;
		ip_plan = '{3'd2, 3'd0, IP_UNBOUND, 3'd5, 3'd4, 3'($urandom_range(0, NUM_REGS - 1))};
		len_plan = '{16'd100, 16'hFFFF, 16'd0, 16'd0, 16'd300, 16'($urandom)};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_cfg(CFG_IP_INDEX, 16'd5);
		write_cfg(CFG_PROG_LEN, 16'd20);
		issue(OP_SETI, 32'hFFFF_FFFF, 0, 3'd1);
		issue(OP_SETI, 32'd7, 0, 3'd2);
		issue(OP_ADDR, 1, 2, 3'd3);
		issue(OP_MULR, 1, 2, 3'd3);
		issue(OP_MULI, 2, 32'hFFFF_FFFF, 3'd4);
		issue(OP_BANR, 1, 2, 3'd0);
		issue(OP_BANI, 1, 32'h8000_0000, 3'd3);
		issue(OP_BORR, 0, 2, 3'd3);
		issue(OP_BORI, 2, 0, 3'd4);
		issue(OP_SETR, 1, 0, 3'd0);
		issue(OP_GTIR, 8, 2, 3'd3);
		issue(OP_GTRR, 1, 2, 3'd4);
		issue(OP_EQIR, 7, 2, 3'd3);
		issue(OP_EQRI, 2, 7, 3'd3);
		// compares against r0 from either side raise the watch
		issue(OP_EQRR, 0, 2, 3'd4);
		issue(OP_EQRR, 1, 0, 3'd4);
		issue(OP_EQRR, 2, 3, 3'd4);
		issue(OP_DIVR, 1, 2, 3'd3);
		issue(OP_DIVI, 2, 0, 3'd3);
		issue(OP_DIVR, 2, 6, 3'd3);
		issue(OP_SETR, 32'hFFFF_FFFF, 0, 3'd1);
		issue(OP_ADDI, 2, 1, 3'd7);
		issue(OP_SETI, 3, 0, 3'd5);
		issue(OP_UNDEF_HI, 1, 2, 3'd1);
		issue(OP_UNDEF_LO, 3, 4, 3'd2);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_cfg(CFG_IP_INDEX, {13'b0, ip_plan[p]});
			write_cfg(CFG_PROG_LEN, len_plan[p]);
			if (p == NUM_PHASES - 1)
				quiet = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_instr(rand_instr());
				if (!quiet && $urandom_range(0, 4) == 0)
					idle_sender($urandom_range(1, 3));
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.due_results.size() == 0)
			$display("six_register_instruction_executor_tb OK");
		else
			$display("six_register_instruction_executor_tb NOT OK");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/srie_pkg.sv
hdl/srie_div.sv
hdl/srie_datapath.sv
hdl/srie_ctrl.sv
hdl/six_register_instruction_executor.sv
hdl/srie_checker.sv
verif/six_register_instruction_executor_tb.sv
